@@ design/mtk_pkg.sv @@
package mtk_pkg;

    localparam int TEXT_CAP_DEF = 160;
    localparam logic [15:0] WINDOW_RESET = 16'd900;

    localparam logic [3:0] KEY_SPACE = 4'd0;
    localparam logic [3:0] KEY_MAX = 4'd9;
    localparam logic [6:0] CHAR_SPACE = 7'h20;

    typedef enum logic [2:0] {
        REQ_KEY       = 3'd0,
        REQ_SPACE     = 3'd1,
        REQ_BACKSPACE = 3'd2,
        REQ_TICK      = 3'd3,
        REQ_READ      = 3'd4,
        REQ_CLEAR     = 3'd5
    } req_t;

    // where the character for a read request comes from
    typedef enum logic [1:0] {
        RD_NONE  = 2'd0,
        RD_STORE = 2'd1,
        RD_PEND  = 2'd2
    } rd_src_t;

    typedef struct packed {
        logic [7:0] text_len;
        logic       pending_valid;
        logic [6:0] pend_ascii;
    } status_t;

    // letters of a key, first letter in the lowest 7 bits
    function automatic logic [27:0] key_letters(logic [3:0] key);
        logic [27:0] l;
        unique case (key)
            4'd0:    l = {7'h20, 7'h20, 7'h20, 7'h20};
            4'd1:    l = {7'h21, 7'h3F, 7'h2C, 7'h2E};
            4'd2:    l = {7'h00, 7'h63, 7'h62, 7'h61};
            4'd3:    l = {7'h00, 7'h66, 7'h65, 7'h64};
            4'd4:    l = {7'h00, 7'h69, 7'h68, 7'h67};
            4'd5:    l = {7'h00, 7'h6C, 7'h6B, 7'h6A};
            4'd6:    l = {7'h00, 7'h6F, 7'h6E, 7'h6D};
            4'd7:    l = {7'h73, 7'h72, 7'h71, 7'h70};
            4'd8:    l = {7'h00, 7'h76, 7'h75, 7'h74};
            4'd9:    l = {7'h7A, 7'h79, 7'h78, 7'h77};
            default: l = '0;
        endcase
        return l;
    endfunction

    function automatic logic [6:0] letter_at(logic [3:0] key, logic [1:0] pos);
        logic [27:0] l;
        logic [6:0]  c;
        l = key_letters(key);
        unique case (pos)
            2'd0: c = l[6:0];
            2'd1: c = l[13:7];
            2'd2: c = l[20:14];
            2'd3: c = l[27:21];
        endcase
        return c;
    endfunction

    function automatic logic [2:0] key_count(logic [3:0] key);
        logic [2:0] n;
        unique case (key)
            4'd0:                      n = 3'd1;
            4'd1, 4'd7, 4'd9:          n = 3'd4;
            4'd2, 4'd3, 4'd4, 4'd5,
            4'd6, 4'd8:                n = 3'd3;
            default:                   n = 3'd1;
        endcase
        return n;
    endfunction

endpackage

@@ design/multitap_keypad_text_entry.sv @@
// Multi-tap keypad text entry. Each input beat is one request (key press, space,
// backspace, tick, read character, clear) and yields exactly one output beat
// with the committed text length, the pending character and, for a read, the
// displayed character at read_index. A new request is taken every cycle while
// m_tready does not stall the output; each beat passes stage 1, which holds
// the status during the registered store read, then the output register. The
// store is split into an even and an odd bank so that a space that also commits
// the pending letter writes two characters in the same cycle. Store contents
// are never cleared: only positions below the text length are ever read, so
// the block is ready right after reset. commit_window_ms (APB offset 0, reset
// 900) sets how long a repeated press of the same key keeps cycling its letters.
module multitap_keypad_text_entry #(
    parameter int TEXT_CAP = mtk_pkg::TEXT_CAP_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // key_code[3:0], now_ms[35:4], read_index[43:36], zero
    input  logic [2:0]  s_tuser,   // req_type[2:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // text_len[7:0], pending_valid[8], pend_ascii[15:9],
                                   // read_char[22:16], zero
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LEN_W = $clog2(TEXT_CAP + 1);
    localparam int BANK_DEPTH = (TEXT_CAP + 1) / 2;
    localparam int BANK_AW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    // register port: one register, commit_window_ms
    logic [15:0] window_reg;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {16'd0, window_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= mtk_pkg::WINDOW_RESET;
        end
        else if (psel && penable && pwrite && pready && !paddr[2])
        begin
            window_reg <= pwdata[15:0];
        end
    end

    // request decode
    logic          s_accept;
    logic          advance;
    mtk_pkg::req_t req;
    logic [3:0]    key;
    logic [31:0]   now;
    logic [7:0]    idx;

    assign s_accept = s_tvalid && s_tready;
    assign req      = mtk_pkg::req_t'(s_tuser);
    assign key      = s_tdata[3:0];
    assign now      = s_tdata[35:4];
    assign idx      = s_tdata[43:36];

    // edit state and next-state logic
    mtk_pkg::status_t status;
    mtk_pkg::rd_src_t rd_src;
    logic [6:0]       rd_char;
    logic             wr0_en, wr1_en;
    logic [6:0]       wr0_char, wr1_char;
    logic [LEN_W-1:0] wr_pos, wr_pos1;

    mtk_edit #(
        .TEXT_CAP (TEXT_CAP)
    ) u_edit (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (s_accept),
        .req      (req),
        .key      (key),
        .now      (now),
        .idx      (idx),
        .window   (window_reg),
        .status   (status),
        .rd_src   (rd_src),
        .rd_char  (rd_char),
        .wr0_en   (wr0_en),
        .wr0_char (wr0_char),
        .wr1_en   (wr1_en),
        .wr1_char (wr1_char),
        .wr_pos   (wr_pos)
    );

    assign wr_pos1 = wr_pos + LEN_W'(1);

    // text store: even positions in bank 0, odd positions in bank 1
    logic [1:0] bank_rd_en;
    logic [6:0] bank_rd [2];

    for (genvar b = 0; b < 2; b++)
    begin : g_bank
        logic               slot0_here;
        logic               wen;
        logic [BANK_AW-1:0] waddr;
        logic [6:0]         wdata;

        assign slot0_here = (wr_pos[0] == 1'(b));
        assign wen = s_accept && ((wr0_en && slot0_here) || (wr1_en && !slot0_here));
        assign waddr = slot0_here ? BANK_AW'(wr_pos >> 1) : BANK_AW'(wr_pos1 >> 1);
        assign wdata = slot0_here ? wr0_char : wr1_char;
        assign bank_rd_en[b] = s_accept && (rd_src == mtk_pkg::RD_STORE) && (idx[0] == 1'(b));

        mtk_ram #(
            .WIDTH (7),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .clk     (clk),
            .wr_en   (wen),
            .wr_addr (waddr),
            .wr_data (wdata),
            .rd_en   (bank_rd_en[b]),
            .rd_addr (BANK_AW'(idx >> 1)),
            .rd_data (bank_rd[b])
        );
    end

    // stage 1: status captured while the store read is in flight
    logic             s1_valid_reg;
    mtk_pkg::status_t s1_status_reg;
    mtk_pkg::rd_src_t s1_src_reg;
    logic             s1_bank_reg;
    logic [6:0]       s1_char_reg;

    // output register
    logic             out_valid_reg;
    logic [23:0]      out_tdata_reg, out_tdata_next;
    logic [6:0]       rc;

    assign advance  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_status_reg <= status;
            s1_src_reg    <= rd_src;
            s1_bank_reg   <= idx[0];
            s1_char_reg   <= rd_char;
        end
        if (advance)
        begin
            out_tdata_reg <= out_tdata_next;
        end
    end

    always_comb
    begin
        unique case (s1_src_reg)
            mtk_pkg::RD_STORE: rc = bank_rd[s1_bank_reg];
            mtk_pkg::RD_PEND:  rc = s1_char_reg;
            default:           rc = 7'd0;
        endcase
    end

    assign out_tdata_next = {1'b0, rc, s1_status_reg.pend_ascii,
                             s1_status_reg.pending_valid, s1_status_reg.text_len};

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_tdata_reg;

`ifndef SYNTHESIS
    // the second write slot is only used together with the first
    a_wr_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && wr1_en) |-> wr0_en)
        else $error("second store write without first");

    a_rd_bank: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(bank_rd_en) && ((bank_rd_en == 2'b00) || s_accept))
        else $error("bad store read enable");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && (req == mtk_pkg::REQ_CLEAR)) |=>
            ((s1_status_reg.text_len == 8'd0) && !s1_status_reg.pending_valid))
        else $error("clear left state behind");

    a_pend_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[8]) |-> (m_tdata[15:9] == 7'd0))
        else $error("pending char without pending flag");
`endif

endmodule

@@ design/mtk_ram.sv @@
module mtk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/mtk_edit.sv @@
module mtk_edit #(
    parameter int TEXT_CAP = mtk_pkg::TEXT_CAP_DEF,
    localparam int LEN_W = $clog2(TEXT_CAP + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  mtk_pkg::req_t       req,
    input  logic [3:0]          key,
    input  logic [31:0]         now,
    input  logic [7:0]          idx,
    input  logic [15:0]         window,
    output mtk_pkg::status_t    status,
    output mtk_pkg::rd_src_t    rd_src,
    output logic [6:0]          rd_char,
    output logic                wr0_en,
    output logic [6:0]          wr0_char,
    output logic                wr1_en,
    output logic [6:0]          wr1_char,
    output logic [LEN_W-1:0]    wr_pos
);

    localparam logic [LEN_W-1:0] CAP_L = LEN_W'(TEXT_CAP);
    localparam int CW = ((LEN_W > 8) ? LEN_W : 8) + 1;

    logic [LEN_W-1:0] len_reg, len_next;
    logic             pend_v_reg, pend_v_next;
    logic [6:0]       pend_code_reg, pend_code_next;
    logic [3:0]       pend_key_reg, pend_key_next;
    logic [1:0]       cyc_reg, cyc_next;
    logic [31:0]      last_reg, last_next;

    logic             room, commit_ok, room_c, late, same, space_req;
    logic [LEN_W-1:0] len_c;
    logic [31:0]      elapsed;
    logic [2:0]       cyc_inc, count;
    logic [1:0]       cyc_step;
    logic [LEN_W+7:0] len_wide;
    logic [CW-1:0]    idx_w, len_w;

    assign room      = len_reg < CAP_L;
    assign commit_ok = pend_v_reg && room;
    assign len_c     = len_reg + LEN_W'(commit_ok);
    assign room_c    = len_c < CAP_L;
    assign elapsed   = now - last_reg;
    assign late      = elapsed >= {16'd0, window};
    assign same      = pend_v_reg && (key == pend_key_reg) && !late;
    assign count     = mtk_pkg::key_count(key);
    assign cyc_inc   = {1'b0, cyc_reg} + 3'd1;
    assign cyc_step  = (cyc_inc == count) ? 2'd0 : cyc_inc[1:0];

    always_comb
    begin
        len_next       = len_reg;
        pend_v_next    = pend_v_reg;
        pend_code_next = pend_code_reg;
        pend_key_next  = pend_key_reg;
        cyc_next       = cyc_reg;
        last_next      = last_reg;
        wr0_en         = 1'b0;
        wr0_char       = pend_code_reg;
        wr1_en         = 1'b0;
        wr1_char       = mtk_pkg::CHAR_SPACE;
        space_req      = 1'b0;

        unique case (req)
            mtk_pkg::REQ_KEY:
            begin
                if (key == mtk_pkg::KEY_SPACE)
                begin
                    space_req = 1'b1;
                end
                else if (key <= mtk_pkg::KEY_MAX)
                begin
                    if (same)
                    begin
                        cyc_next       = cyc_step;
                        pend_code_next = mtk_pkg::letter_at(key, cyc_step);
                        last_next      = now;
                    end
                    else
                    begin
                        wr0_en      = commit_ok;
                        pend_v_next = 1'b0;
                        len_next    = len_c;
                        if (room_c)
                        begin
                            cyc_next       = 2'd0;
                            pend_code_next = mtk_pkg::letter_at(key, 2'd0);
                            pend_key_next  = key;
                            pend_v_next    = 1'b1;
                            last_next      = now;
                        end
                    end
                end
            end
            mtk_pkg::REQ_SPACE:
            begin
                space_req = 1'b1;
            end
            mtk_pkg::REQ_BACKSPACE:
            begin
                if (pend_v_reg)
                begin
                    pend_v_next   = 1'b0;
                    pend_key_next = 4'd0;
                    cyc_next      = 2'd0;
                end
                else if (len_reg != '0)
                begin
                    len_next = len_reg - LEN_W'(1);
                end
            end
            mtk_pkg::REQ_TICK:
            begin
                if (pend_v_reg && late)
                begin
                    wr0_en      = commit_ok;
                    pend_v_next = 1'b0;
                    len_next    = len_c;
                end
            end
            mtk_pkg::REQ_READ:
            begin
            end
            mtk_pkg::REQ_CLEAR:
            begin
                len_next       = '0;
                pend_v_next    = 1'b0;
                pend_code_next = 7'd0;
                pend_key_next  = 4'd0;
                cyc_next       = 2'd0;
                last_next      = 32'd0;
            end
            default:
            begin
            end
        endcase

        // commit the pending letter, then the space in the next slot; with nothing pending the space alone
        if (space_req)
        begin
            wr0_en      = commit_ok || room;
            wr0_char    = commit_ok ? pend_code_reg : mtk_pkg::CHAR_SPACE;
            wr1_en      = commit_ok && room_c;
            pend_v_next = 1'b0;
            len_next    = len_c + LEN_W'(room_c);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            pend_v_reg    <= 1'b0;
            pend_code_reg <= 7'd0;
            pend_key_reg  <= 4'd0;
            cyc_reg       <= 2'd0;
            last_reg      <= 32'd0;
        end
        else if (step)
        begin
            len_reg       <= len_next;
            pend_v_reg    <= pend_v_next;
            pend_code_reg <= pend_code_next;
            pend_key_reg  <= pend_key_next;
            cyc_reg       <= cyc_next;
            last_reg      <= last_next;
        end
    end

    assign wr_pos = len_reg;

    assign len_wide               = (LEN_W + 8)'(len_next);
    assign status.text_len        = len_wide[7:0];
    assign status.pending_valid   = pend_v_next;
    assign status.pend_ascii      = pend_v_next ? pend_code_next : 7'd0;

    // read looks at the text as it stands before the request
    assign idx_w   = CW'(idx);
    assign len_w   = CW'(len_reg);
    assign rd_char = pend_code_reg;

    always_comb
    begin
        if (req != mtk_pkg::REQ_READ)
        begin
            rd_src = mtk_pkg::RD_NONE;
        end
        else if (idx_w < len_w)
        begin
            rd_src = mtk_pkg::RD_STORE;
        end
        else if ((idx_w == len_w) && pend_v_reg)
        begin
            rd_src = mtk_pkg::RD_PEND;
        end
        else
        begin
            rd_src = mtk_pkg::RD_NONE;
        end
    end

endmodule
